[rtl/tea_pkg.sv]
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and the round mixing function for the TEA cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package tea_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned ROUND_COUNT = 32;
    localparam int unsigned KEY_WORDS   = 4;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;
    // delta times the round count, modulo 2^32
    localparam logic [WORD_W-1:0] DEC_SUM_INIT = WORD_W'(TEA_DELTA * ROUND_COUNT);

    localparam logic [WORD_W-1:0] KEY0_RESET = 32'h6f6e_6e61;
    localparam logic [WORD_W-1:0] KEY1_RESET = 32'h676e_6979;
    localparam logic [WORD_W-1:0] KEY2_RESET = 32'h6e6f_6d20;
    localparam logic [WORD_W-1:0] KEY3_RESET = 32'h0079_655b;

    typedef enum logic {
        CMD_ENC = 1'b0,
        CMD_DEC = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        KEY_W0 = 2'd0,
        KEY_W1 = 2'd1,
        KEY_W2 = 2'd2,
        KEY_W3 = 2'd3
    } t_key_idx;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key_set;

    // one beat moving down the row of round cells
    typedef struct packed {
        logic              valid;
        t_cmd              cmd;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
    } t_round_beat;

    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] w,
        input logic [WORD_W-1:0] s,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        logic [WORD_W-1:0] t_a;
        logic [WORD_W-1:0] t_b;
        logic [WORD_W-1:0] t_c;
        t_a = (w << 4) + ka;
        t_b = w + s;
        t_c = (w >> 5) + kb;
        return t_a ^ t_b ^ t_c;
    endfunction

endpackage

`default_nettype wire

[rtl/tea_ifs.sv]
// ----------------------------------------------------------------------------
// tea channel interfaces
// Valid/ready channels for the key writes, the input blocks and the results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tea_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tea_pkg::CFG_IDX_W-1:0]  index;
    logic [tea_pkg::WORD_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface tea_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [tea_pkg::WORD_W-1:0]  in_word0;
    logic [tea_pkg::WORD_W-1:0]  in_word1;

    modport source (output valid, output command, output in_word0, output in_word1,
                    input ready);
    modport sink   (input valid, input command, input in_word0, input in_word1,
                    output ready);
endinterface

interface tea_out_if;
    logic                        valid;
    logic                        ready;
    logic [tea_pkg::WORD_W-1:0]  out_word0;
    logic [tea_pkg::WORD_W-1:0]  out_word1;

    modport source (output valid, output out_word0, output out_word1, input ready);
    modport sink   (input valid, input out_word0, input out_word1, output ready);
endinterface

`default_nettype wire

[rtl/tea_key_regs.sv]
// ----------------------------------------------------------------------------
// tea_key_regs
// The four 32-bit key registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_key_regs (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    tea_cfg_if.sink              i_cfg,
    output tea_pkg::t_key_set    o_key
);

    tea_pkg::t_key_set r_key;

    assign i_cfg.ready = 1'b1;
    assign o_key       = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[tea_pkg::KEY_W0] <= tea_pkg::KEY0_RESET;
            r_key[tea_pkg::KEY_W1] <= tea_pkg::KEY1_RESET;
            r_key[tea_pkg::KEY_W2] <= tea_pkg::KEY2_RESET;
            r_key[tea_pkg::KEY_W3] <= tea_pkg::KEY3_RESET;
        end else if (i_cfg.valid) begin
            unique case (tea_pkg::t_key_idx'(i_cfg.index))
                tea_pkg::KEY_W0: r_key[tea_pkg::KEY_W0] <= i_cfg.data;
                tea_pkg::KEY_W1: r_key[tea_pkg::KEY_W1] <= i_cfg.data;
                tea_pkg::KEY_W2: r_key[tea_pkg::KEY_W2] <= i_cfg.data;
                tea_pkg::KEY_W3: r_key[tea_pkg::KEY_W3] <= i_cfg.data;
                default: r_key <= r_key;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/tea_round_cell.sv]
// ----------------------------------------------------------------------------
// tea_round_cell
// One TEA round as two registered half-rounds; passes the next round's sum on.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_round_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire tea_pkg::t_key_set     i_key,
    input  wire tea_pkg::t_round_beat  i_beat,
    output tea_pkg::t_round_beat       o_beat
);

    tea_pkg::t_round_beat r_mid;
    tea_pkg::t_round_beat r_out;
    tea_pkg::t_round_beat n_mid;
    tea_pkg::t_round_beat n_out;

    logic [tea_pkg::WORD_W-1:0] mix_a;
    logic [tea_pkg::WORD_W-1:0] mix_b;

    // first half: encrypt updates word 0, decrypt undoes word 1
    always_comb begin
        n_mid = i_beat;
        if (i_beat.cmd == tea_pkg::CMD_DEC) begin
            mix_a    = tea_pkg::tea_mix(i_beat.w0, i_beat.sum,
                                        i_key[tea_pkg::KEY_W2], i_key[tea_pkg::KEY_W3]);
            n_mid.w1 = i_beat.w1 - mix_a;
        end else begin
            mix_a    = tea_pkg::tea_mix(i_beat.w1, i_beat.sum,
                                        i_key[tea_pkg::KEY_W0], i_key[tea_pkg::KEY_W1]);
            n_mid.w0 = i_beat.w0 + mix_a;
        end
    end

    // second half, and the sum for the next cell
    always_comb begin
        n_out = r_mid;
        if (r_mid.cmd == tea_pkg::CMD_DEC) begin
            mix_b     = tea_pkg::tea_mix(r_mid.w1, r_mid.sum,
                                         i_key[tea_pkg::KEY_W0], i_key[tea_pkg::KEY_W1]);
            n_out.w0  = r_mid.w0 - mix_b;
            n_out.sum = r_mid.sum - tea_pkg::TEA_DELTA;
        end else begin
            mix_b     = tea_pkg::tea_mix(r_mid.w0, r_mid.sum,
                                         i_key[tea_pkg::KEY_W2], i_key[tea_pkg::KEY_W3]);
            n_out.w1  = r_mid.w1 + mix_b;
            n_out.sum = r_mid.sum + tea_pkg::TEA_DELTA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.valid <= 1'b0;
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_mid <= n_mid;
            r_out <= n_out;
        end
    end

    assign o_beat = r_out;

endmodule

`default_nettype wire

[rtl/tea_out_buf.sv]
// ----------------------------------------------------------------------------
// tea_out_buf
// Output register plus skid register; decouples the result channel's ready
// from the advance of the round row.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_out_buf (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire tea_pkg::t_round_beat  i_beat,
    output logic                       o_advance,
    tea_out_if.source                  o_out
);

    logic                        r_out_valid;
    logic [tea_pkg::WORD_W-1:0]  r_out_w0;
    logic [tea_pkg::WORD_W-1:0]  r_out_w1;
    logic                        r_skid_valid;
    logic [tea_pkg::WORD_W-1:0]  r_skid_w0;
    logic [tea_pkg::WORD_W-1:0]  r_skid_w1;
    logic                        arrive;
    logic                        take;

    // the row moves whenever the skid register is free
    assign o_advance = !r_skid_valid;
    assign arrive    = o_advance && i_beat.valid;
    assign take      = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (take && r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (take || !r_out_valid) begin
                r_out_valid  <= arrive;
            end else if (arrive) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (take && r_skid_valid) begin
            r_out_w0 <= r_skid_w0;
            r_out_w1 <= r_skid_w1;
        end else if ((take || !r_out_valid) && arrive) begin
            r_out_w0 <= i_beat.w0;
            r_out_w1 <= i_beat.w1;
        end else if (arrive) begin
            r_skid_w0 <= i_beat.w0;
            r_skid_w1 <= i_beat.w1;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_word0 = r_out_w0;
    assign o_out.out_word1 = r_out_w1;

endmodule

`default_nettype wire

[rtl/tea_block_cipher_unit.sv]
// ----------------------------------------------------------------------------
// tea_block_cipher_unit
// TEA encrypt/decrypt over a row of 32 round cells, one block per cycle.
// Path: each input beat passes two registers in every round cell, then the
//   output register, before the result is valid.
// Throughput: one block per cycle; the row stalls only while the skid
//   register is full, which happens when the result channel holds back.
// Reset: the key registers return to their default key and the row empties.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_block_cipher_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tea_cfg_if.sink    i_cfg,
    tea_in_if.sink     i_in,
    tea_out_if.source  o_out
);

    tea_pkg::t_key_set     key;
    tea_pkg::t_round_beat  chain [tea_pkg::ROUND_COUNT+1];
    logic                  advance;

    tea_key_regs u_keys (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_key   (key)
    );

    assign i_in.ready = advance;

    always_comb begin
        chain[0].valid = i_in.valid;
        chain[0].cmd   = tea_pkg::t_cmd'(i_in.command);
        chain[0].sum   = (i_in.command == tea_pkg::CMD_DEC) ? tea_pkg::DEC_SUM_INIT
                                                            : tea_pkg::TEA_DELTA;
        chain[0].w0    = i_in.in_word0;
        chain[0].w1    = i_in.in_word1;
    end

    for (genvar g = 0; g < tea_pkg::ROUND_COUNT; g++) begin : g_round
        tea_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_key   (key),
            .i_beat  (chain[g]),
            .o_beat  (chain[g+1])
        );
    end

    tea_out_buf u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (chain[tea_pkg::ROUND_COUNT]),
        .o_advance (advance),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
